// ===== rtl/core/mtdso_pkg.sv =====
// Package for the MIDI-tuned dual sine oscillator: types, constants and
// elaboration-time tables (quarter-wave sine magnitudes, note phase steps).
// No dependencies.
`default_nettype none

package mtdso_pkg;

  // Fixed configuration
  localparam int CHANNELS        = 2;
  localparam int SAMPLE_RATE_HZ  = 44100;
  localparam int SINE_TABLE_BITS = 10;
  localparam int PHASE_BITS      = 32;
  localparam int QTR_BITS        = SINE_TABLE_BITS - 2;
  localparam int QSIZE           = 1 << QTR_BITS;
  localparam int SAMPLE_W        = 16;
  localparam int MAG_W           = 15;
  localparam int NOTE_W          = 7;
  localparam int NOTES           = 1 << NOTE_W;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] TRIGGER_RESET = 8'h91;

  // Reset tuning: 400 Hz and 500 Hz, rounded to nearest
  localparam logic [PHASE_BITS-1:0] STEP_400 = PHASE_BITS'(
    ((64'd400 << PHASE_BITS) + 64'(SAMPLE_RATE_HZ / 2)) / 64'(SAMPLE_RATE_HZ));
  localparam logic [PHASE_BITS-1:0] STEP_500 = PHASE_BITS'(
    ((64'd500 << PHASE_BITS) + 64'(SAMPLE_RATE_HZ / 2)) / 64'(SAMPLE_RATE_HZ));

  // round(2^31 * 2^(k/12))
  localparam logic [31:0] SEMITONE_Q31 [12] = '{
    32'd2147483648, 32'd2275179671, 32'd2410468894, 32'd2553802834,
    32'd2705659851, 32'd2866546760, 32'd3037000500, 32'd3217589947,
    32'd3408917801, 32'd3611622603, 32'd3826380858, 32'd4053909304
  };

  // Odd Taylor coefficients of sin(pi/2*u)/u in powers of u^2, Q30
  localparam longint SIN_COEF [5] = '{
    64'sd1686629713, -64'sd693598668, 64'sd85569306, -64'sd5026996, 64'sd172272
  };

  // Item types
  typedef struct packed {
    logic              mode;
    logic [7:0]        status_byte;
    logic [NOTE_W-1:0] note_number;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
  } out_item_t;

  // Commands passed from front to back
  typedef enum logic {
    CMD_TICK,
    CMD_RETUNE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [PHASE_BITS-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } cmd_push_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  typedef logic [QSIZE-1:0][MAG_W-1:0]      sine_rom_t;
  typedef logic [NOTES-1:0][PHASE_BITS-1:0] note_rom_t;

  // Q30 product truncated toward zero; b is never negative
  function automatic longint mul_q30(input longint a, input longint b);
    logic [63:0] m;
    if (a < 0) begin
      m = (64'(-a) * 64'(b)) >> 30;
      return -longint'(m);
    end
    m = (64'(a) * 64'(b)) >> 30;
    return longint'(m);
  endfunction

  // Magnitude of sin(pi/2 * num/QSIZE), scaled to 32767
  function automatic logic [MAG_W-1:0] sine_mag(input int num);
    longint      u;
    longint      u2;
    longint      p;
    longint      s;
    logic [63:0] v;
    u  = longint'(num) <<< (30 - QTR_BITS);
    u2 = mul_q30(u, u);
    p  = SIN_COEF[4];
    for (int k = 3; k >= 0; k--) begin
      p = SIN_COEF[k] + mul_q30(p, u2);
    end
    s = mul_q30(p, u);
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    if (s < 0) s = 0;
    v = (64'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
    return v[MAG_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i < QSIZE; i++) begin
      rom[i] = sine_mag(i);
    end
    return rom;
  endfunction

  // Shift-subtract quotient, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (rem >= d) begin
        rem  = rem - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Equal-tempered phase step per MIDI note, A4 (note 69) = 440 Hz
  function automatic note_rom_t build_note_rom();
    note_rom_t   rom;
    int          oct;
    int          k;
    int          e;
    logic [63:0] num;
    logic [63:0] den;
    // note 0 maps to d = 51: octave 4, semitone 3
    oct = 4;
    k   = 3;
    for (int n = 0; n < NOTES; n++) begin
      num = 64'd440 * 64'(SEMITONE_Q31[k]);
      den = 64'(SAMPLE_RATE_HZ);
      e   = oct - 41 + PHASE_BITS;
      if (e >= 0) num = num << e;
      else        den = den << (-e);
      rom[n] = PHASE_BITS'(udiv64(num + (den >> 1), den));
      k = k + 1;
      if (k == 12) begin
        k   = 0;
        oct = oct + 1;
      end
    end
    return rom;
  endfunction

  localparam sine_rom_t        SINE_ROM  = build_sine_rom();
  localparam logic [MAG_W-1:0] SINE_PEAK = sine_mag(QSIZE);
  localparam note_rom_t        NOTE_ROM  = build_note_rom();

endpackage

`default_nettype wire

// ===== rtl/core/midi_tuned_dual_sine_oscillator_unit.sv =====
// Top level of the MIDI-tuned dual sine oscillator: front end, command
// queue and back end. Uses mtdso_pkg, mtdso_front, mtdso_queue, mtdso_back.
//
// Use: the input channel (in_valid_i / in_stall_o / in_data_i) carries ticks
// (mode 0) and MIDI messages (mode 1). Each tick yields one stereo frame on
// the output channel (out_valid_o / out_stall_i / out_data_o); a MIDI message
// whose status byte matches the trigger register retunes channel 0 to the
// note's equal-tempered pitch and channel 1 to 3/2 of it, and yields nothing.
// The trigger register is written through cfg_we_i / cfg_wdata_i; the user
// must write it only while idle, which the block does not enforce. Throughput:
// one transaction per cycle while the output is not stalled, set by the
// combinational phase add and quarter-wave table read in the back end. A
// two-entry queue parts front from back, so in_stall_o rises only when it is
// full, e.g. while the receiver holds a frame with out_stall_i high; a held
// frame stays unchanged until taken. Reset clears both phases, restores the
// 400 Hz / 500 Hz tuning and trigger 0x91, and empties queue and output.
`default_nettype none

module midi_tuned_dual_sine_oscillator_unit import mtdso_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire in_item_t   in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_item_t       out_data_o
);

  cmd_push_t   push;
  queue_head_t head;
  logic        queue_full;
  logic        pop;

  mtdso_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .queue_full_i (queue_full),
    .push_o       (push)
  );

  mtdso_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (queue_full),
    .head_o (head)
  );

  mtdso_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/mtdso_front.sv =====
// Front end: accepts input transactions, holds the trigger register and
// turns ticks and matching MIDI messages into commands. Uses mtdso_pkg.
`default_nettype none

module mtdso_front import mtdso_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire in_item_t   in_data_i,
  input  wire logic       queue_full_i,
  output cmd_push_t       push_o
);

  logic [7:0] trigger_q;
  logic       accept;

  // Trigger status register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_q <= TRIGGER_RESET;
    end else if (cfg_we_i) begin
      trigger_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;

  // Classify: tick, retune, or drop a non-matching MIDI message
  always_comb begin
    push_o.push     = 1'b0;
    push_o.cmd.kind = CMD_TICK;
    push_o.cmd.step = NOTE_ROM[in_data_i.note_number];
    if (accept) begin
      if (!in_data_i.mode) begin
        push_o.push = 1'b1;
      end else if (in_data_i.status_byte == trigger_q) begin
        push_o.push     = 1'b1;
        push_o.cmd.kind = CMD_RETUNE;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mtdso_queue.sv =====
// Two-entry command queue between front and back ends.
// Uses mtdso_pkg for the command types.
`default_nettype none

module mtdso_queue import mtdso_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cmd_push_t push_i,
  input  wire logic      pop_i,
  output logic           full_o,
  output queue_head_t    head_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i.push && !pop_i) count_d = count_q + 1'b1;
    if (!push_i.push && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push |-> !full_o)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid)
    else $error("queue pop while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/mtdso_back.sv =====
// Back end: phase accumulators, phase steps, sine lookup and the output
// register. Executes tick and retune commands in order. Uses mtdso_pkg.
`default_nettype none

module mtdso_back import mtdso_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire queue_head_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o
);

  logic [PHASE_BITS-1:0]      phase_q [CHANNELS];
  logic [PHASE_BITS-1:0]      phase_d [CHANNELS];
  logic [PHASE_BITS-1:0]      step_q  [CHANNELS];
  logic [PHASE_BITS-1:0]      step_d  [CHANNELS];
  logic [PHASE_BITS+1:0]      step_x3;
  logic [SINE_TABLE_BITS-1:0] idx     [CHANNELS];
  logic [QTR_BITS-1:0]        rom_idx [CHANNELS];
  logic [MAG_W-1:0]           mag     [CHANNELS];
  logic [SAMPLE_W-1:0]        mag_ext [CHANNELS];
  logic [SAMPLE_W-1:0]        smp     [CHANNELS];
  logic                       out_valid_q, out_valid_d;
  out_item_t                  out_data_q;
  logic                       tick_go;
  logic                       retune_go;

  // A retune never needs the output register; a tick needs it free
  assign pop_o     = head_i.valid &&
                     (head_i.cmd.kind == CMD_RETUNE || !out_valid_q || !out_stall_i);
  assign tick_go   = pop_o && (head_i.cmd.kind == CMD_TICK);
  assign retune_go = pop_o && (head_i.cmd.kind == CMD_RETUNE);

  // On a retune, channel 1 gets 3/2 of channel 0's step, rounded half up
  assign step_x3 = {1'b0, head_i.cmd.step, 1'b0} + {2'b00, head_i.cmd.step} + 1'b1;

  // Quarter-wave sine lookup per channel
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      idx[c]     = phase_q[c][PHASE_BITS-1 -: SINE_TABLE_BITS];
      rom_idx[c] = idx[c][SINE_TABLE_BITS-2] ? (QTR_BITS'(0) - idx[c][QTR_BITS-1:0])
                                             : idx[c][QTR_BITS-1:0];
      if (idx[c][SINE_TABLE_BITS-2] && (idx[c][QTR_BITS-1:0] == '0)) begin
        mag[c] = SINE_PEAK;
      end else begin
        mag[c] = SINE_ROM[rom_idx[c]];
      end
      mag_ext[c] = {1'b0, mag[c]};
      smp[c]     = idx[c][SINE_TABLE_BITS-1] ? (SAMPLE_W'(0) - mag_ext[c]) : mag_ext[c];
    end
  end

  // Phase and step updates
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      phase_d[c] = tick_go ? (phase_q[c] + step_q[c]) : phase_q[c];
      step_d[c]  = step_q[c];
    end
    if (retune_go) begin
      step_d[0] = head_i.cmd.step;
      step_d[1] = step_x3[PHASE_BITS:1];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (tick_go)           out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q[0]  <= '0;
      phase_q[1]  <= '0;
      step_q[0]   <= STEP_400;
      step_q[1]   <= STEP_500;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (tick_go) begin
      out_data_q.sample_left  <= smp[0];
      out_data_q.sample_right <= smp[1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_tick_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_go |-> !(out_valid_q && out_stall_i))
    else $error("tick overwrote a held frame");

  a_tick_gives_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_go |=> out_valid_q)
    else $error("tick did not produce a frame");

  a_phase_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_go |=> phase_q[0] == $past(phase_q[0] + step_q[0]))
    else $error("channel 0 phase did not advance by its step");

  a_retune_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    retune_go |=> step_q[0] == $past(head_i.cmd.step) && $stable(phase_q[0]))
    else $error("retune did not load the note step");

  a_sample_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q.sample_left != 16'sh8000
                 && out_data_q.sample_right != 16'sh8000)
    else $error("sample outside symmetric range");

endmodule

`default_nettype wire
